// ----- rtl/gb3_pkg.sv -----
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants of the 3x3 Gaussian blur unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

  localparam int PIX_W   = 8;   // grey value
  localparam int FW_W    = 12;  // frame_width register
  localparam int FH_W    = 16;  // frame_height register
  localparam int ROW_W   = 17;  // input row count runs one past the frame height
  localparam int CFG_W   = 16;  // widest configuration register
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column, index 0 is the row above, index 2 the row below.
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    logic top;     // row above lies outside the frame
    logic bottom;  // row below lies outside the frame
  } border_t;

  // Per-item control passed from the address stage to the window stage.
  typedef struct packed {
    logic    emit;
    logic    col0;   // item lands in column zero, result is a row's last column
    logic    left;   // result is a row's first column
    logic    last;
    border_t brd;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/gaussian_blur_3x3_unit.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_unit
// 3x3 Gaussian blur of an 8-bit grey raster stream with replicated borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (in_kind = 0). After each
// frame the host sends frame_width+1 drain items (in_kind = 1) that flush the
// remaining results; a drain item sent while image rows are still expected is
// taken and ignored. Each result on the out_ channel carries the filtered
// value and a flag on the last pixel of the frame.
// While the output does not stall, a transfer is one pixel per clock: the line
// memory is read at the item's column on the transfer and written back from the
// window stage as it moves on, so a new item is taken every cycle. A result
// passes through the window stage and the output register after the transfer of
// the item that completes its neighbourhood, frame_width+1 items after its pixel.
// When the receiver stalls, the output register holds its result and in_stall
// rises in the same cycle until the result is taken.
// Reset clears the position counters and loads 640 x 480. The line memory is
// not cleared: its contents before the second row of a frame only feed rows
// that border replication replaces. A configuration write restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_kind,
  input  wire logic [gb3_pkg::PIX_W-1:0]          in_pixel_in,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [gb3_pkg::PIX_W-1:0]          out_pixel_out,
  output logic                                    out_last_of_frame,
  input  wire logic                               cfg_we,
  input  wire logic [gb3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gb3_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > gb3_pkg::FW_W) ? CW + 1 : gb3_pkg::FW_W;
  localparam int RW = gb3_pkg::ROW_W;
  localparam int HW = gb3_pkg::FH_W;

  // Configuration.
  logic [gb3_pkg::FW_W-1:0] cfg_width_r;
  logic [HW-1:0]            cfg_height_r;

  // Position counters.
  logic [CW-1:0] in_col_r,  in_col_nxt;
  logic [RW-1:0] in_row_r,  in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  // Window stage.
  logic                 s1_v_r;
  gb3_pkg::ctrl_t       s1_ctl_r;
  gb3_pkg::pix_t        s1_pix_r;
  logic [CW-1:0]        s1_addr_r;
  gb3_pkg::col_t        col_a_r;
  gb3_pkg::col_t        col_b_r;

  // Output register.
  logic                 out_valid_r;
  gb3_pkg::pix_t        out_pix_r;
  logic                 out_last_r;

  logic [WW-1:0]        fw_ext;
  logic [WW-1:0]        w_eff;
  logic [RW-1:0]        h_eff;
  logic                 advance;
  logic                 accept;
  logic                 in_frame;
  logic                 active;
  gb3_pkg::pix_t        pix_eff;
  gb3_pkg::ctrl_t       ctl;
  logic                 in_row_end;
  logic                 out_row_end;
  logic                 s1_fire;
  logic [15:0]          ram_rdata;
  logic [15:0]          ram_wdata;
  logic                 fwd_r;
  logic [15:0]          fwd_data_r;
  logic [15:0]          line_rd;
  gb3_pkg::col_t        new_col;
  gb3_pkg::col_t        blur_l;
  gb3_pkg::col_t        blur_r;
  gb3_pkg::pix_t        blur_val;

  // Effective frame size.
  always_comb begin
    fw_ext = WW'(cfg_width_r);
    if (fw_ext < WW'(3)) begin
      w_eff = WW'(3);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    h_eff = (cfg_height_r < HW'(3)) ? RW'(3) : RW'(cfg_height_r);
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign in_frame = in_row_r < h_eff;
  // A drain item inside the frame changes nothing.
  assign active   = accept && !(in_frame && (in_kind == gb3_pkg::KIND_DRAIN));
  assign pix_eff  = in_frame ? in_pixel_in : '0;

  always_comb begin
    ctl.emit       = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
    ctl.col0       = (in_col_r == '0);
    ctl.left       = (out_col_r == '0);
    ctl.brd.top    = (out_row_r == '0);
    ctl.brd.bottom = (RW'(out_row_r) + RW'(1)) >= h_eff;
    out_row_end    = (WW'(out_col_r) + WW'(1)) >= w_eff;
    ctl.last       = out_row_end && ctl.brd.bottom;
    in_row_end     = (WW'(in_col_r) + WW'(1)) >= w_eff;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (active) begin
      if (in_row_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (ctl.emit) begin
        if (ctl.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_row_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= gb3_pkg::FRAME_WIDTH_RST;
      cfg_height_r <= gb3_pkg::FRAME_HEIGHT_RST;
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gb3_pkg::CFG_FRAME_WIDTH:  cfg_width_r  <= cfg_wdata[gb3_pkg::FW_W-1:0];
          gb3_pkg::CFG_FRAME_HEIGHT: cfg_height_r <= cfg_wdata[HW-1:0];
          default: ;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Each entry holds {upper line, lower line} for one column. A column comes
  // back frame_width items later, except at a frame restart where column zero
  // follows column zero; that write-back is forwarded to the read beside it.
  assign s1_fire   = s1_v_r && advance;
  assign line_rd   = fwd_r ? fwd_data_r : ram_rdata;
  assign ram_wdata = {line_rd[7:0], s1_pix_r};

  gb3_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (active),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (active) begin
      fwd_r      <= s1_fire && (s1_addr_r == in_col_r);
      fwd_data_r <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      s1_ctl_r  <= ctl;
      s1_pix_r  <= pix_eff;
      s1_addr_r <= in_col_r;
    end
  end

  assign new_col = {s1_pix_r, line_rd[7:0], line_rd[15:8]};

  // Relative to the window after the shift: a result in column zero finishes
  // the previous row and replicates its centre to the right; a row's first
  // column replicates its centre to the left.
  assign blur_l = (!s1_ctl_r.col0 && s1_ctl_r.left) ? col_b_r : col_a_r;
  assign blur_r = s1_ctl_r.col0 ? col_b_r : new_col;

  gb3_blur u_blur (
    .col_l  (blur_l),
    .col_c  (col_b_r),
    .col_r  (blur_r),
    .brd    (s1_ctl_r.brd),
    .result (blur_val)
  );

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      col_a_r <= col_b_r;
      col_b_r <= new_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_v_r && s1_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pix_r  <= blur_val;
      out_last_r <= s1_ctl_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_out     = out_pix_r;
  assign out_last_of_frame = out_last_r;

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(in_col_r) < w_eff)
    else $error("input column beyond frame width");

  a_ram_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && active && (s1_addr_r == in_col_r)) |=> fwd_r)
    else $error("line memory write not forwarded to a read of the same column");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !advance) |=> (s1_v_r && $stable(s1_addr_r) && $stable(s1_pix_r)))
    else $error("window stage lost its item during a stall");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> ((out_row_r == '0) && (out_col_r == '0)))
    else $error("output counters not restarted after the last pixel");
`endif

endmodule

`default_nettype wire

// ----- rtl/gb3_ram.sv -----
// ----------------------------------------------------------------------------
// gb3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gb3_blur.sv -----
// ----------------------------------------------------------------------------
// gb3_blur
// 1-2-1 by 1-2-1 weighted sum of three window columns, divided by 16.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_blur (
  input  wire gb3_pkg::col_t    col_l,
  input  wire gb3_pkg::col_t    col_c,
  input  wire gb3_pkg::col_t    col_r,
  input  wire gb3_pkg::border_t brd,
  output gb3_pkg::pix_t         result
);

  logic [9:0]  sum_l;
  logic [9:0]  sum_c;
  logic [9:0]  sum_r;
  logic [11:0] total;

  // Vertical 1-2-1 pass; a missing row is replaced by the centre row.
  function automatic logic [9:0] col_sum(gb3_pkg::col_t c, gb3_pkg::border_t b);
    logic [7:0] r0;
    logic [7:0] r2;
    r0 = b.top    ? c[1] : c[0];
    r2 = b.bottom ? c[1] : c[2];
    return 10'(r0) + {1'b0, c[1], 1'b0} + 10'(r2);
  endfunction

  always_comb begin
    sum_l  = col_sum(col_l, brd);
    sum_c  = col_sum(col_c, brd);
    sum_r  = col_sum(col_r, brd);
    total  = 12'(sum_l) + {1'b0, sum_c, 1'b0} + 12'(sum_r);
    result = total[11:4];
  end

endmodule

`default_nettype wire

// ----- verif/tb_gaussian_blur_3x3_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_unit
// Self-checking bench for the 3x3 Gaussian blur unit with replicated borders.
// ----------------------------------------------------------------------------
// A short directed list runs two 3x3 frames: a flat white frame with a drain
// tick inside the frame and a pixel after the frame, whose results are known
// by eye, then a frame of extreme values. Random phases follow with several
// frame sizes, register values outside the legal range included, and truncated
// frames that a register write restarts. Every accepted input transfer is run
// through a local model of the line stores and window, and each output
// transfer is compared with the oldest expected pixel.
// ----------------------------------------------------------------------------

module tb_gaussian_blur_3x3_unit;

  localparam int  MAX_W       = 2048;
  localparam int  IDLE_PCT    = 46;
  localparam int  BOTH_PCT    = 20;
  localparam int  HOLD_CYCLES = 300;
  localparam int  SETTLE      = 4;   // output register sits behind the window stage
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  N_DIR       = 27;
  localparam int  N_PHASE     = 8;

  typedef logic [gb3_pkg::FW_W-1:0]      fw_t;
  typedef logic [gb3_pkg::FH_W-1:0]      fh_t;
  typedef logic [gb3_pkg::CFG_W-1:0]     cfg_t;
  typedef logic [gb3_pkg::CFG_IDX_W-1:0] idx_t;

  typedef struct packed {
    gb3_pkg::pix_t pixel;
    logic          last;
  } blur_res_t;

  typedef struct packed {
    logic          kind;
    gb3_pkg::pix_t pix;
    logic          typed;    // expectation below is used instead of the model
    logic          emit;
    gb3_pkg::pix_t exp_pix;
    logic          exp_last;
  } dir_row_t;

  typedef struct {
    int wreg;
    int hreg;
    int items;
    int send_pct;
    int recv_pct;
    bit hold;
  } phase_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_kind = gb3_pkg::KIND_PIXEL;
  gb3_pkg::pix_t    in_pixel_in = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  gb3_pkg::pix_t    out_pixel_out;
  logic             out_last_of_frame;
  logic             cfg_we = 1'b0;
  idx_t             cfg_index = gb3_pkg::CFG_FRAME_WIDTH;
  cfg_t             cfg_wdata = '0;

  // Expectation typed into the directed list travels beside the payload.
  logic             row_typed = 1'b0;
  logic             row_emit = 1'b0;
  gb3_pkg::pix_t    row_pix = '0;
  logic             row_last = 1'b0;

  int               send_pct = 0;
  int               stall_pct = 0;
  bit               hold_req = 1'b0;
  int               err_cnt = 0;
  int               cycle_cnt = 0;
  blur_res_t        blurred_q[$];

  // Local copy of the filter state.
  gb3_pkg::pix_t    ls_upper[MAX_W];
  gb3_pkg::pix_t    ls_lower[MAX_W];
  gb3_pkg::pix_t    win[3][3];   // [column oldest..newest][row above..below]
  fw_t              fw_reg;
  fh_t              fh_reg;
  int unsigned      in_col, in_row, out_col, out_row;

  dir_row_t dir_rows [N_DIR] = '{
    // Flat white frame: every result is 255, the last one ends the frame.
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_DRAIN, 8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd77,  1'b1, 1'b1, 8'd255, 1'b0},
    '{gb3_pkg::KIND_DRAIN, 8'd0,   1'b1, 1'b1, 8'd255, 1'b0},
    '{gb3_pkg::KIND_DRAIN, 8'd0,   1'b1, 1'b1, 8'd255, 1'b0},
    '{gb3_pkg::KIND_DRAIN, 8'd0,   1'b1, 1'b1, 8'd255, 1'b1},
    // Extreme values, checked against the model.
    '{gb3_pkg::KIND_PIXEL, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd128, 1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd254, 1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd127, 1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_DRAIN, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_DRAIN, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_PIXEL, 8'd170, 1'b0, 1'b0, 8'd0,   1'b0},
    '{gb3_pkg::KIND_DRAIN, 8'd85,  1'b0, 1'b0, 8'd0,   1'b0}
  };

  // Register values below and above the legal range are clamped by the block.
  phase_t phases [N_PHASE] = '{
    '{3,    3,     150, 0,        0,        1'b1},
    '{5,    4,     200, IDLE_PCT, 0,        1'b0},
    '{2,    1,     150, 0,        IDLE_PCT, 1'b0},
    '{17,   6,     300, BOTH_PCT, BOTH_PCT, 1'b0},
    '{4095, 65535, 250, BOTH_PCT, BOTH_PCT, 1'b0},
    '{9,    65535, 250, 0,        IDLE_PCT, 1'b0},
    '{33,   3,     300, 0,        0,        1'b0},
    '{1,    7,     200, BOTH_PCT, BOTH_PCT, 1'b0}
  };

  gaussian_blur_3x3_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_pixel_in       (in_pixel_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_out     (out_pixel_out),
    .out_last_of_frame (out_last_of_frame),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int unsigned eff_width(fw_t wr);
    if (wr < 3) return 3;
    if (wr > MAX_W) return MAX_W;
    return wr;
  endfunction

  function automatic int unsigned eff_height(fh_t hr);
    return (hr < 3) ? 3 : hr;
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void apply_reg(idx_t idx, cfg_t val);
    if (idx == gb3_pkg::CFG_FRAME_WIDTH) begin
      fw_reg = val[gb3_pkg::FW_W-1:0];
    end else begin
      fh_reg = val[gb3_pkg::FH_W-1:0];
    end
    restart_frame();
  endfunction

  // 1-2-1 by 1-2-1 weighted sum over three window columns, divided by 16.
  function automatic int unsigned blur_sum(int cl, int cc, int cr, bit top, bit bottom);
    int          cols[3];
    int          rows[3];
    int unsigned acc;
    cols = '{cl, cc, cr};
    rows = '{top ? 1 : 0, 1, bottom ? 1 : 2};
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc += win[cols[j]][rows[i]] * ((i == 1) ? 2 : 1) * ((j == 1) ? 2 : 1);
      end
    end
    return acc >> 4;
  endfunction

  // Advances the filter state by one transfer; returns 1 when a pixel comes out.
  function automatic bit blur_step(input logic kind, input gb3_pkg::pix_t pix_i,
                                   output gb3_pkg::pix_t res_pix, output logic res_last);
    int unsigned   w, h, c, acc;
    bit            emit, top, bottom;
    gb3_pkg::pix_t p, v0, v1;
    w = eff_width(fw_reg);
    h = eff_height(fh_reg);
    p = pix_i;
    acc = 0;
    res_pix = '0;
    res_last = 1'b0;
    if (in_row < h) begin
      if (kind == gb3_pkg::KIND_DRAIN) return 1'b0;
    end else begin
      p = '0;
    end
    c = (in_col >= w) ? w - 1 : in_col;
    emit = (in_row >= 2) || (in_row == 1 && c >= 1);
    top = (out_row == 0);
    bottom = (out_row + 1 >= h);
    v0 = ls_upper[c];
    v1 = ls_lower[c];
    ls_upper[c] = v1;
    ls_lower[c] = p;
    // In column zero the result is the last pixel of a row, so the right
    // neighbour repeats the centre column before the window moves on.
    if (c == 0 && emit) acc = blur_sum(1, 2, 2, top, bottom);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        win[i][j] = win[i + 1][j];
      end
    end
    win[2][0] = v0;
    win[2][1] = v1;
    win[2][2] = p;
    if (c != 0 && emit) acc = blur_sum((out_col == 0) ? 1 : 0, 1, 2, top, bottom);
    in_col = c + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return 1'b0;
    res_pix = acc[gb3_pkg::PIX_W-1:0];
    if (out_col + 1 >= w && out_row + 1 >= h) begin
      res_last = 1'b1;
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  function automatic gb3_pkg::pix_t rand_pixel();
    if ($urandom_range(4) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return gb3_pkg::pix_t'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic kind, input gb3_pkg::pix_t pix, input dir_row_t row);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_pixel_in <= pix;
    row_typed   <= row.typed;
    row_emit    <= row.emit;
    row_pix     <= row.exp_pix;
    row_last    <= row.exp_last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_frame(input cfg_t wr, input cfg_t hr);
    cfg_we    <= 1'b1;
    cfg_index <= gb3_pkg::CFG_FRAME_WIDTH;
    cfg_wdata <= wr;
    @(negedge clk);
    cfg_index <= gb3_pkg::CFG_FRAME_HEIGHT;
    cfg_wdata <= hr;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Waits until every expected pixel has come out and the pipeline is empty.
  task automatic wait_drained(input int extra);
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input phase_t ph);
    int unsigned w, h, flen, pos, sent;
    dir_row_t    none;
    none = '0;
    w = eff_width(fw_t'(ph.wreg));
    h = eff_height(fh_t'(ph.hreg));
    flen = w * h + w + 1;
    pos = 0;
    sent = 0;
    send_pct  = ph.send_pct;
    stall_pct = ph.recv_pct;
    set_frame(cfg_t'(ph.wreg), cfg_t'(ph.hreg));
    while (sent < ph.items) begin
      if (ph.hold && sent == 40) hold_req = 1'b1;
      if (pos < w * h) begin
        // A stray drain tick inside the frame is dropped by the block.
        if ($urandom_range(99) < 4) begin
          send_item(gb3_pkg::KIND_DRAIN, gb3_pkg::pix_t'($urandom), none);
        end
        send_item(gb3_pkg::KIND_PIXEL, rand_pixel(), none);
      end else if ($urandom_range(4) == 0) begin
        send_item(gb3_pkg::KIND_PIXEL, gb3_pkg::pix_t'($urandom), none);
      end else begin
        send_item(gb3_pkg::KIND_DRAIN, gb3_pkg::pix_t'($urandom), none);
      end
      sent++;
      pos = (pos + 1 == flen) ? 0 : pos + 1;
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: random stalls, and one long hold-off that backs up the input.
  initial begin
    int hold_cnt;
    forever begin
      @(negedge clk);
      if (hold_req && out_valid) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    gb3_pkg::pix_t p_pix;
    logic          p_last;
    bit            p_emit;
    blur_res_t     want;
    if (rst_n) begin
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        p_emit = blur_step(in_kind, in_pixel_in, p_pix, p_last);
        if (row_typed) begin
          if (row_emit) blurred_q.push_back('{row_pix, row_last});
        end else if (p_emit) begin
          blurred_q.push_back('{p_pix, p_last});
        end
      end
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          $error("unexpected result: pixel_out %0d, last_of_frame %0b",
                 out_pixel_out, out_last_of_frame);
          err_cnt++;
        end else begin
          want = blurred_q.pop_front();
          if (out_pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel, out_pixel_out);
            err_cnt++;
          end
          if (out_last_of_frame !== want.last) begin
            $error("last_of_frame: expected %0b, actual %0b", want.last, out_last_of_frame);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_gaussian_blur_3x3_unit: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      ls_upper[i] = '0;
      ls_lower[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win[i][j] = '0;
      end
    end
    fw_reg = gb3_pkg::FRAME_WIDTH_RST;
    fh_reg = gb3_pkg::FRAME_HEIGHT_RST;
    restart_frame();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Both registers below range, so the directed frames are 3x3.
    set_frame('0, '0);
    @(negedge clk);
    for (int i = 0; i < N_DIR; i++) begin
      send_item(dir_rows[i].kind, dir_rows[i].pix, dir_rows[i]);
    end
    in_valid  <= 1'b0;
    row_typed <= 1'b0;

    for (int i = 0; i < N_PHASE; i++) begin
      wait_drained(SETTLE);
      run_phase(phases[i]);
    end

    wait_drained(2 * SETTLE);
    if (err_cnt == 0) begin
      $display("tb_gaussian_blur_3x3_unit: done, clean");
    end else begin
      $display("tb_gaussian_blur_3x3_unit: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gb3_pkg.sv
rtl/gb3_ram.sv
rtl/gb3_blur.sv
rtl/gaussian_blur_3x3_unit.sv
verif/tb_gaussian_blur_3x3_unit.sv
